### src/cell_grid_store_with_activity_tracking_assert.svh
// Assertion macros used by the cell grid store controller.
`ifndef CELL_GRID_STORE_WITH_ACTIVITY_TRACKING_ASSERT_SVH
`define CELL_GRID_STORE_WITH_ACTIVITY_TRACKING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cgs_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package cgs_pkg;

   localparam int DEF_GRID_WIDTH  = 128;
   localparam int DEF_GRID_HEIGHT = 64;
   localparam int DEF_FRAME_BITS  = 16;

   localparam int REQ_TYPE_W = 2;
   localparam int COORD_W    = 8;
   localparam int MATERIAL_W = 8;
   localparam int FRAME_IN_W = 16;
   localparam int COUNT_W    = 14;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_MARK  = 2'd2;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic update;
      logic stamp_en;
      logic load_rsp;
   } cgs_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_inb;
      logic req_write;
      logic stamp_last;
   } cgs_status_type;

endpackage

### src/cell_grid_store_with_activity_tracking.sv
// Top level of the cell grid store with activity tracking.
//
// The request channel (req_valid / req_stall) carries one transaction per cell
// access: a read, a write or a mark-dirty of the cell at req_cell_x, req_cell_y.
// Every request transaction produces exactly one response transaction on the
// rsp_valid / rsp_stall channel with the cell code (reads only), the in-bounds
// flag, the saturated count of nonzero cells and the activity flag of the row.
// Transactions are handled one at a time by the controller, which walks the
// datapath through a memory read, for in-bounds requests an update and, for
// writes, a walk over the nine neighbour window positions, stamping those on
// the grid through the single write port of the stamp memory. After acceptance
// the controller passes its read, update and stamp states as the request needs
// and loads the response from its done state, then returns to idle to accept
// the next request. After reset the block sweeps all GRID_WIDTH * GRID_HEIGHT
// cells, one per cycle, holding req_stall high meanwhile.
// The response sits in an output register; while the receiver stalls it holds
// still, and a following request is processed but waits for the register.
module cell_grid_store_with_activity_tracking import cgs_pkg::*; #(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
   parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [COORD_W-1:0]    req_cell_x,
   input  logic [COORD_W-1:0]    req_cell_y,
   input  logic [MATERIAL_W-1:0] req_material,
   input  logic [FRAME_IN_W-1:0] req_frame_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MATERIAL_W-1:0] rsp_read_value,
   output logic                  rsp_on_grid,
   output logic [COUNT_W-1:0]    rsp_active_count,
   output logic                  rsp_row_active
);

   // Command and status between the sequencer and the datapath.
   cgs_cmd_type    cmd;
   cgs_status_type status;

   cgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the grid memories, the per-row nonzero counts that
   // give the row activity flags, the nonzero cell count and the response
   // registers.
   cgs_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .FRAME_BITS  (FRAME_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_type         (req_type),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_material     (req_material),
      .req_frame_number (req_frame_number),
      .rsp_read_value   (rsp_read_value),
      .rsp_on_grid      (rsp_on_grid),
      .rsp_active_count (rsp_active_count),
      .rsp_row_active   (rsp_row_active)
   );

endmodule

### src/cgs_datapath.sv
// Datapath: request registers, grid memories, counters and response registers.
module cgs_datapath import cgs_pkg::*; #(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
   parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cgs_cmd_type           cmd,
   output cgs_status_type        status,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [COORD_W-1:0]    req_cell_x,
   input  logic [COORD_W-1:0]    req_cell_y,
   input  logic [MATERIAL_W-1:0] req_material,
   input  logic [FRAME_IN_W-1:0] req_frame_number,
   output logic [MATERIAL_W-1:0] rsp_read_value,
   output logic                  rsp_on_grid,
   output logic [COUNT_W-1:0]    rsp_active_count,
   output logic                  rsp_row_active
);

   localparam int CELLS   = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int YW      = $clog2(GRID_HEIGHT);
   localparam int RCNT_W  = $clog2(GRID_WIDTH + 1);
   localparam int NZ_W    = $clog2(CELLS + 1);
   localparam logic [1:0] NBR_LAST = 2'd2;

   // Captured request.
   logic [REQ_TYPE_W-1:0] req_type_ff;
   logic [COORD_W-1:0]    req_x_ff;
   logic [COORD_W-1:0]    req_y_ff;
   logic [MATERIAL_W-1:0] req_material_ff;
   logic [FRAME_BITS-1:0] req_frame_ff;
   logic [FRAME_BITS-1:0] req_frame_in;
   logic                  req_inb_ff;
   logic                  req_inb_in;
   logic [CELL_AW-1:0]    req_idx_ff;
   logic [CELL_AW-1:0]    req_idx_in;
   logic [31:0]           frame_wide;

   // Grid stores. The active flag of a cell equals its material being nonzero,
   // so the row flag comes from a per-row count of nonzero cells.
   logic [MATERIAL_W-1:0] material_mem [CELLS];
   logic                  dirty_mem    [CELLS];
   logic [FRAME_BITS-1:0] frame_mem    [CELLS];
   logic [RCNT_W-1:0]     rcnt_mem     [GRID_HEIGHT];
   logic [GRID_HEIGHT-1:0] row_dirty_ff;

   logic [MATERIAL_W-1:0] mat_rd_ff;
   logic [RCNT_W-1:0]     rcnt_rd_ff;

   logic [CELL_AW-1:0] clear_addr_ff;
   logic               clear_last;
   logic               clear_in_rows;

   logic [NZ_W-1:0]   nonzero_ff;
   logic [NZ_W-1:0]   nonzero_in;
   logic [RCNT_W-1:0] rcnt_new;
   logic              is_write;
   logic              is_read;
   logic              is_mark;
   logic              changed;
   logic              gain;
   logic              lose;
   logic              mat_we;
   logic              dirty_we;

   logic [MATERIAL_W-1:0] res_value_ff;
   logic                  res_row_ff;

   logic [1:0]         dx_ff;
   logic [1:0]         dy_ff;
   logic [COORD_W:0]   sx;
   logic [COORD_W:0]   sy;
   logic [COORD_W:0]   nx;
   logic [COORD_W:0]   ny;
   logic               x_ok;
   logic               y_ok;
   logic               stamp_we;
   logic               stamp_last;
   logic [CELL_AW-1:0] stamp_idx;

   logic [31:0]        nz_wide;
   logic [COUNT_W-1:0] count_sat;

   logic [MATERIAL_W-1:0] rsp_read_value_ff;
   logic                  rsp_on_grid_ff;
   logic [COUNT_W-1:0]    rsp_active_count_ff;
   logic                  rsp_row_active_ff;

   // Request capture.
   always_comb begin
      frame_wide   = {{(32 - FRAME_IN_W){1'b0}}, req_frame_number};
      req_frame_in = frame_wide[FRAME_BITS-1:0];
      req_inb_in   = (req_cell_x < COORD_W'(GRID_WIDTH)) &&
                     (req_cell_y < COORD_W'(GRID_HEIGHT));
      req_idx_in   = CELL_AW'(CELL_AW'(req_cell_y) * CELL_AW'(GRID_WIDTH)) +
                     CELL_AW'(req_cell_x);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff     <= req_type;
         req_x_ff        <= req_cell_x;
         req_y_ff        <= req_cell_y;
         req_material_ff <= req_material;
         req_frame_ff    <= req_frame_in;
         req_inb_ff      <= req_inb_in;
         req_idx_ff      <= req_idx_in;
      end
   end

   // Update decode.
   always_comb begin
      is_write = (req_type_ff == REQ_WRITE);
      is_read  = (req_type_ff == REQ_READ);
      is_mark  = (req_type_ff == REQ_MARK);
      changed  = (req_material_ff != mat_rd_ff);
      gain     = is_write && (mat_rd_ff == '0) && (req_material_ff != '0);
      lose     = is_write && (mat_rd_ff != '0) && (req_material_ff == '0);
      mat_we   = cmd.update && is_write && changed;
      dirty_we = cmd.update && ((is_write && changed) || is_mark);
      if (gain) begin
         rcnt_new = rcnt_rd_ff + RCNT_W'(1);
      end else if (lose) begin
         rcnt_new = rcnt_rd_ff - RCNT_W'(1);
      end else begin
         rcnt_new = rcnt_rd_ff;
      end
      nonzero_in = nonzero_ff;
      if (cmd.update && gain) begin
         nonzero_in = nonzero_ff + NZ_W'(1);
      end else if (cmd.update && lose && (nonzero_ff != '0)) begin
         nonzero_in = nonzero_ff - NZ_W'(1);
      end
   end

   // Reset sweep.
   assign clear_last    = (clear_addr_ff == CELL_AW'(CELLS - 1));
   assign clear_in_rows = (clear_addr_ff < CELL_AW'(GRID_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_en && !clear_last) begin
         clear_addr_ff <= clear_addr_ff + CELL_AW'(1);
      end
   end

   // Neighbour stamping walks a 3 by 3 window, one position a cycle.
   always_comb begin
      sx         = {1'b0, req_x_ff} + (COORD_W + 1)'(dx_ff);
      sy         = {1'b0, req_y_ff} + (COORD_W + 1)'(dy_ff);
      nx         = sx - (COORD_W + 1)'(1);
      ny         = sy - (COORD_W + 1)'(1);
      x_ok       = (sx != '0) && (nx < (COORD_W + 1)'(GRID_WIDTH));
      y_ok       = (sy != '0) && (ny < (COORD_W + 1)'(GRID_HEIGHT));
      stamp_we   = cmd.stamp_en && x_ok && y_ok;
      stamp_last = (dx_ff == NBR_LAST) && (dy_ff == NBR_LAST);
      stamp_idx  = CELL_AW'(CELL_AW'(ny[COORD_W-1:0]) * CELL_AW'(GRID_WIDTH)) +
                   CELL_AW'(nx[COORD_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         dx_ff <= '0;
         dy_ff <= '0;
      end else if (cmd.stamp_en) begin
         if (dx_ff == NBR_LAST) begin
            dx_ff <= '0;
            dy_ff <= dy_ff + 2'd1;
         end else begin
            dx_ff <= dx_ff + 2'd1;
         end
      end
   end

   // Memories.
   always_ff @(posedge clock) begin
      mat_rd_ff <= material_mem[req_idx_ff];
      if (cmd.clear_en) begin
         material_mem[clear_addr_ff] <= '0;
      end else if (mat_we) begin
         material_mem[req_idx_ff] <= req_material_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         dirty_mem[clear_addr_ff] <= 1'b0;
      end else if (dirty_we) begin
         dirty_mem[req_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         frame_mem[clear_addr_ff] <= '0;
      end else if (stamp_we) begin
         frame_mem[stamp_idx] <= req_frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      rcnt_rd_ff <= rcnt_mem[req_y_ff[YW-1:0]];
      if (cmd.clear_en && clear_in_rows) begin
         rcnt_mem[clear_addr_ff[YW-1:0]] <= '0;
      end else if (cmd.update && is_write) begin
         rcnt_mem[req_y_ff[YW-1:0]] <= rcnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_dirty_ff <= '0;
         nonzero_ff   <= '0;
      end else begin
         nonzero_ff <= nonzero_in;
         if (dirty_we) begin
            row_dirty_ff[req_y_ff[YW-1:0]] <= 1'b1;
         end
      end
   end

   // Result of the current transaction; zero unless an in-bounds update runs.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_value_ff <= '0;
         res_row_ff   <= 1'b0;
      end else if (cmd.update) begin
         res_value_ff <= is_read ? mat_rd_ff : '0;
         res_row_ff   <= (rcnt_new != '0);
      end
   end

   always_comb begin
      nz_wide   = 32'(nonzero_ff);
      count_sat = (nz_wide > 32'(COUNT_MAX)) ? COUNT_MAX : nz_wide[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_read_value_ff   <= res_value_ff;
         rsp_on_grid_ff      <= req_inb_ff;
         rsp_active_count_ff <= count_sat;
         rsp_row_active_ff   <= res_row_ff;
      end
   end

   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_on_grid      = rsp_on_grid_ff;
   assign rsp_active_count = rsp_active_count_ff;
   assign rsp_row_active   = rsp_row_active_ff;

   assign status.clear_last = clear_last;
   assign status.req_inb    = req_inb_ff;
   assign status.req_write  = is_write;
   assign status.stamp_last = stamp_last;

endmodule

### src/cgs_ctrl.sv
// Controller state machine sequencing the reset sweep and each transaction.
`include "cell_grid_store_with_activity_tracking_assert.svh"

module cgs_ctrl import cgs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  cgs_status_type status,
   output cgs_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_STAMP  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      slot_free = !rsp_valid_ff || !rsp_stall;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = status.req_inb ? S_UPDATE : S_DONE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.req_write ? S_STAMP : S_DONE;
         end
         S_STAMP: begin
            cmd.stamp_en = 1'b1;
            if (status.stamp_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `CGS_ASSERT_HOLDS(a_stamp_only_on_write, clock, reset, state_ff == S_STAMP, status.req_write && status.req_inb, "neighbour stamping for a transaction that is not an in-bounds write")
   `CGS_ASSERT_NEXT(a_stamp_runs_full_window, clock, reset, (state_ff == S_STAMP) && !status.stamp_last, state_ff == S_STAMP, "neighbour stamping left before the last window position")
   `CGS_ASSERT_NEXT(a_done_with_free_slot, clock, reset, (state_ff == S_DONE) && !rsp_valid_ff, (state_ff == S_IDLE) && rsp_valid_ff, "finished transaction not handed to an empty response register")

endmodule

### bench/tb_top.sv
// Self-checking testbench for the cell grid store with activity tracking.
`timescale 1ns / 1ps

module tb_top import cgs_pkg::*; ();

   // The block is instantiated at its default size, so the grid predictor uses the
   // same dimensions.
   localparam int GRID_W = DEF_GRID_WIDTH;
   localparam int GRID_H = DEF_GRID_HEIGHT;
   localparam int CELL_COUNT = GRID_W * GRID_H;

   // The unused request code has no name in the package; it behaves as a no-op.
   localparam logic [REQ_TYPE_W-1:0] REQ_NOOP = 2'd3;

   // Grid border coordinates at the port width.
   localparam logic [COORD_W-1:0] X_LAST = COORD_W'(GRID_W - 1);
   localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(GRID_H - 1);
   localparam logic [COORD_W-1:0] X_PAST = COORD_W'(GRID_W);
   localparam logic [COORD_W-1:0] Y_PAST = COORD_W'(GRID_H);
   localparam logic [COORD_W-1:0] Y_NEXT_LAST = COORD_W'(GRID_H - 2);

   // The slowest correct run is far below this. It covers the clearing sweep after
   // reset, about 1700 requests, the longest sender gaps and response stalls,
   // and the long hold-off, several times over.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;

   // One response transaction, field by field.
   typedef struct packed {
      logic [MATERIAL_W-1:0] read_value;
      logic                  on_grid;
      logic [COUNT_W-1:0]    active_count;
      logic                  row_active;
   } cell_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [REQ_TYPE_W-1:0] req_type = REQ_READ;
   logic [COORD_W-1:0]    req_cell_x = '0;
   logic [COORD_W-1:0]    req_cell_y = '0;
   logic [MATERIAL_W-1:0] req_material = '0;
   logic [FRAME_IN_W-1:0] req_frame_number = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [MATERIAL_W-1:0] rsp_read_value;
   logic                  rsp_on_grid;
   logic [COUNT_W-1:0]    rsp_active_count;
   logic                  rsp_row_active;

   // Predicted grid contents. Dirty flags and frame stamps never reach the ports,
   // so only the state that shapes a response is kept here.
   logic [MATERIAL_W-1:0] grid_material [CELL_COUNT];
   logic                  cell_busy [CELL_COUNT];
   logic                  row_busy [GRID_H];
   int                    nonzero_cells;

   // Responses still owed by the block, oldest first.
   cell_result_type       pending_results [$];

   // Traffic shaping, set per test phase.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_left = 0;

   int cycle_count = 0;
   int mismatch_count = 0;
   int checked_count = 0;
   int read_count = 0;
   int write_count = 0;
   int mark_count = 0;
   int noop_count = 0;
   int outside_count = 0;

   cell_grid_store_with_activity_tracking dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_material     (req_material),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_on_grid      (rsp_on_grid),
      .rsp_active_count (rsp_active_count),
      .rsp_row_active   (rsp_row_active)
   );

   always #2 clock = ~clock;

   // Applies one accepted request to the predicted grid and returns the response
   // the block owes for it. A write between zero and nonzero adjusts the nonzero
   // count; any in-bounds write sets or clears the cell's activity, and clearing
   // it rescans the whole row to decide whether the row stays active.
   function automatic cell_result_type apply_grid_request(
      input logic [REQ_TYPE_W-1:0] kind,
      input logic [COORD_W-1:0]    x,
      input logic [COORD_W-1:0]    y,
      input logic [MATERIAL_W-1:0] mat
   );
      cell_result_type res;
      int              idx;
      logic            any_busy;
      res = '0;
      if (x < GRID_W && y < GRID_H) begin
         idx = int'(y) * GRID_W + int'(x);
         res.on_grid = 1'b1;
         case (kind)
            REQ_READ: begin
               res.read_value = grid_material[idx];
            end
            REQ_WRITE: begin
               if (mat != grid_material[idx]) begin
                  if (grid_material[idx] == '0)
                     nonzero_cells++;
                  else if (mat == '0 && nonzero_cells > 0)
                     nonzero_cells--;
                  grid_material[idx] = mat;
               end
               if (mat != '0) begin
                  cell_busy[idx] = 1'b1;
                  row_busy[y] = 1'b1;
               end else begin
                  cell_busy[idx] = 1'b0;
                  any_busy = 1'b0;
                  for (int col = 0; col < GRID_W; col++)
                     if (cell_busy[int'(y) * GRID_W + col])
                        any_busy = 1'b1;
                  row_busy[y] = any_busy;
               end
            end
            // Mark-dirty only sets flags that are invisible here, and the spare
            // code does nothing at all; both still report the row flag.
            default: ;
         endcase
         res.row_active = row_busy[y];
      end
      res.active_count = (nonzero_cells > int'(COUNT_MAX)) ? COUNT_MAX
                                                           : COUNT_W'(nonzero_cells);
      return res;
   endfunction

   // Offers one request transaction. Inputs move only at the falling edge; the
   // request is taken at the first rising edge with req_stall low, and its
   // expected response is queued at that edge. Valid stays high into the next
   // call when no gap is drawn, so back-to-back traffic has no bubbles.
   task automatic send_request(
      input logic [REQ_TYPE_W-1:0] kind,
      input logic [COORD_W-1:0]    x,
      input logic [COORD_W-1:0]    y,
      input logic [MATERIAL_W-1:0] mat,
      input logic [FRAME_IN_W-1:0] frame
   );
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_cell_x       <= x;
      req_cell_y       <= y;
      req_material     <= mat;
      req_frame_number <= frame;
      do
         @(posedge clock);
      while (req_stall);
      pending_results.push_back(apply_grid_request(kind, x, y, mat));
      if (x >= GRID_W || y >= GRID_H)
         outside_count++;
      case (kind)
         REQ_READ:  read_count++;
         REQ_WRITE: write_count++;
         REQ_MARK:  mark_count++;
         default:   noop_count++;
      endcase
   endtask

   // Receiver side: either a long hold-off is counted down here, or the
   // response channel stalls at random at the rate of the current phase.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Response checker: every accepted response is matched against the oldest
   // prediction, field by field.
   always @(posedge clock) begin : check_responses
      cell_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none expected: value %0d grid %0b count %0d row %0b",
                     $time, rsp_read_value, rsp_on_grid, rsp_active_count,
                     rsp_row_active);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_read_value !== want.read_value) begin
               mismatch_count++;
               $display("%0t: read_value expected %0d, got %0d",
                        $time, want.read_value, rsp_read_value);
            end
            if (rsp_on_grid !== want.on_grid) begin
               mismatch_count++;
               $display("%0t: on_grid expected %0b, got %0b",
                        $time, want.on_grid, rsp_on_grid);
            end
            if (rsp_active_count !== want.active_count) begin
               mismatch_count++;
               $display("%0t: active_count expected %0d, got %0d",
                        $time, want.active_count, rsp_active_count);
            end
            if (rsp_row_active !== want.row_active) begin
               mismatch_count++;
               $display("%0t: row_active expected %0b, got %0b",
                        $time, want.row_active, rsp_row_active);
            end
         end
      end
   end

   // Watchdog on the whole run, clearing sweep included.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Fresh grid before the first request, then reset is held and released.
   // The block's own clearing sweep follows, with req_stall held high.
   task automatic test_reset;
      for (int i = 0; i < CELL_COUNT; i++) begin
         grid_material[i] = '0;
         cell_busy[i] = 1'b0;
      end
      for (int r = 0; r < GRID_H; r++)
         row_busy[r] = 1'b0;
      nonzero_cells = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   // Reads of an empty grid, the grid border and everything just past it, and
   // the spare request code inside and outside the grid.
   task automatic test_bounds_and_reads;
      send_request(REQ_READ, 8'd0, 8'd0, 8'hFF, 16'hFFFF);
      send_request(REQ_READ, X_LAST, Y_LAST, 8'h00, 16'h0000);
      send_request(REQ_READ, X_PAST, 8'd0, 8'h00, 16'h0000);
      send_request(REQ_READ, 8'd0, Y_PAST, 8'h00, 16'h0000);
      send_request(REQ_READ, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(REQ_NOOP, 8'd5, 8'd5, 8'h33, 16'h1234);
      send_request(REQ_NOOP, 8'hFF, 8'd5, 8'h33, 16'h1234);
   endtask

   // Writes at the grid corners, so the neighbour stamps hit every edge, a
   // repeated write with no change, a write and a mark-dirty outside the grid, and
   // the row flag surviving one cleared cell but not the last one.
   task automatic test_writes_and_row_flags;
      send_request(REQ_WRITE, 8'd0, 8'd0, 8'hFF, 16'hFFFF);
      send_request(REQ_WRITE, 8'd0, 8'd0, 8'hFF, 16'h0001);
      send_request(REQ_WRITE, X_LAST, Y_LAST, 8'h01, 16'h0000);
      send_request(REQ_WRITE, X_LAST, 8'd0, 8'hAA, 16'h8000);
      send_request(REQ_WRITE, 8'd0, Y_LAST, 8'h55, 16'h7FFF);
      send_request(REQ_READ, 8'd0, 8'd0, 8'h00, 16'h0000);
      send_request(REQ_READ, X_LAST, Y_LAST, 8'h00, 16'h0000);
      send_request(REQ_MARK, 8'd5, 8'd5, 8'h00, 16'h0000);
      send_request(REQ_MARK, 8'd5, Y_PAST, 8'h00, 16'h0000);
      send_request(REQ_WRITE, 8'd200, 8'd10, 8'h07, 16'h4444);
      send_request(REQ_WRITE, 8'd0, 8'd0, 8'h00, 16'h0002);
      send_request(REQ_WRITE, 8'd3, 8'd3, 8'h80, 16'h0003);
      send_request(REQ_WRITE, 8'd100, 8'd3, 8'h04, 16'h0004);
      send_request(REQ_WRITE, 8'd3, 8'd3, 8'h00, 16'h0005);
      send_request(REQ_WRITE, 8'd100, 8'd3, 8'h00, 16'h0006);
      send_request(REQ_WRITE, 8'd100, 8'd3, 8'h00, 16'h0007);
      send_request(REQ_READ, 8'd100, 8'd3, 8'h00, 16'h0000);
   endtask

   // Random traffic. Most requests land on a few rows and near the left and
   // right borders so cells fill and empty again and rows keep toggling; the
   // rest spread over the grid or fall outside it.
   task automatic test_random_traffic(input int count, input int idle_percent,
                                      input int stall_percent);
      logic [REQ_TYPE_W-1:0] kind;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [MATERIAL_W-1:0] mat;
      int                    pick;
      send_idle_pct = idle_percent;
      rsp_stall_pct = stall_percent;
      repeat (count) begin
         pick = $urandom_range(99);
         kind = (pick < 35) ? REQ_READ : (pick < 75) ? REQ_WRITE :
                (pick < 90) ? REQ_MARK : REQ_NOOP;
         pick = $urandom_range(99);
         if (pick < 70) begin
            case ($urandom_range(3))
               0:       y = 8'd0;
               1:       y = 8'd1;
               2:       y = Y_NEXT_LAST;
               default: y = Y_LAST;
            endcase
            x = $urandom_range(1) ? COORD_W'($urandom_range(5))
                                  : COORD_W'($urandom_range(GRID_W - 1, GRID_W - 6));
         end else if (pick < 90) begin
            x = COORD_W'($urandom_range(GRID_W - 1));
            y = COORD_W'($urandom_range(GRID_H - 1));
         end else if ($urandom_range(1)) begin
            x = COORD_W'($urandom_range(255));
            y = COORD_W'($urandom_range(255, GRID_H));
         end else begin
            x = COORD_W'($urandom_range(255, GRID_W));
            y = COORD_W'($urandom_range(255));
         end
         mat = ($urandom_range(99) < 40) ? '0 : MATERIAL_W'($urandom_range(255, 1));
         send_request(kind, x, y, mat, FRAME_IN_W'($urandom_range(16'hFFFF)));
      end
   endtask

   // The receiver refuses responses for a long stretch while requests keep
   // coming, so the output register and the controller fill and the block must
   // push back on its input. Afterwards everything drains in order.
   task automatic test_response_hold_off;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      for (int i = 0; i < 40; i++)
         send_request((i % 2 == 0) ? REQ_WRITE : REQ_READ, COORD_W'(i % 8), 8'd2,
                      MATERIAL_W'($urandom_range(255)), FRAME_IN_W'($urandom_range(16'hFFFF)));
   endtask

   initial begin
      test_reset();
      test_bounds_and_reads();
      test_writes_and_row_flags();
      test_random_traffic(450, 0, 0);
      test_random_traffic(400, 82, 0);
      test_random_traffic(400, 0, 82);
      test_response_hold_off();
      test_random_traffic(400, 14, 14);
      @(negedge clock);
      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d reads, %0d writes, %0d mark-dirty,",
               read_count + write_count + mark_count + noop_count, read_count, write_count,
               mark_count);
      $display("%0d no-op and %0d outside the grid; checked %0d responses under gap-free,",
               noop_count, outside_count, checked_count);
      $display("sparse, stalled and mixed traffic");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
